### rtl/core/m3i_pkg.sv
// Shared stage numbers and types for the 3x3 matrix inverse pipeline.
`default_nettype none

package m3i_pkg;

  // Pipeline stage indexes. The remaining divider stages follow the last one named here.
  localparam int STG_PROD  = 0;  // cofactor partial products
  localparam int STG_COF   = 1;  // cofactors
  localparam int STG_DPART = 2;  // determinant partial products, cofactor magnitudes
  localparam int STG_DTERM = 3;  // determinant terms
  localparam int STG_DSUM  = 4;  // determinant
  localparam int STG_DMAG  = 5;  // determinant magnitude and flags
  localparam int STG_DIV0  = 6;  // first divider stage (range check)

  // Determinant status carried alongside the divider stages.
  typedef struct packed {
    logic neg;
    logic zero;
  } det_flags_t;

endpackage

`default_nettype wire

### rtl/core/m3i_in_if.sv
// Input channel: one matrix word with valid and ready.
`default_nettype none

interface m3i_in_if #(
  parameter int WORD_BITS = 32
) ();
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] m00;
  logic signed [WORD_BITS-1:0] m01;
  logic signed [WORD_BITS-1:0] m02;
  logic signed [WORD_BITS-1:0] m10;
  logic signed [WORD_BITS-1:0] m11;
  logic signed [WORD_BITS-1:0] m12;
  logic signed [WORD_BITS-1:0] m20;
  logic signed [WORD_BITS-1:0] m21;
  logic signed [WORD_BITS-1:0] m22;

  modport source (
    output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
    input  ready
  );
  modport sink (
    input  valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
    output ready
  );
endinterface

`default_nettype wire

### rtl/core/m3i_out_if.sv
// Output channel: one inverse word with valid and ready.
`default_nettype none

interface m3i_out_if #(
  parameter int WORD_BITS = 32
) ();
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] r00;
  logic signed [WORD_BITS-1:0] r01;
  logic signed [WORD_BITS-1:0] r02;
  logic signed [WORD_BITS-1:0] r10;
  logic signed [WORD_BITS-1:0] r11;
  logic signed [WORD_BITS-1:0] r12;
  logic signed [WORD_BITS-1:0] r20;
  logic signed [WORD_BITS-1:0] r21;
  logic signed [WORD_BITS-1:0] r22;
  logic                        singular;

  modport source (
    output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, singular,
    input  ready
  );
  modport sink (
    input  valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, singular,
    output ready
  );
endinterface

`default_nettype wire

### rtl/core/m3i_cof_lane.sv
// One cofactor lane: p*q - r*s over two registered stages.
`default_nettype none

module m3i_cof_lane import m3i_pkg::*; #(
  parameter int W  = 32,
  parameter int NS = 39
) (
  input  logic                clk,
  input  logic [NS-1:0]       en,
  input  logic signed [W-1:0] p,
  input  logic signed [W-1:0] q,
  input  logic signed [W-1:0] r,
  input  logic signed [W-1:0] s,
  output logic signed [2*W:0] cof
);

  logic signed [2*W-1:0] pq;
  logic signed [2*W-1:0] rs;

  // Both products are exact in 2W bits; the difference needs one more bit.
  always_ff @(posedge clk) begin
    if (en[STG_PROD]) begin
      pq <= p * q;
      rs <= r * s;
    end
    if (en[STG_COF]) begin
      cof <= {pq[2*W-1], pq} - {rs[2*W-1], rs};
    end
  end

endmodule

`default_nettype wire

### rtl/core/m3i_det_merge.sv
// Merging stage: determinant from column a and the first cofactor row.
`default_nettype none

module m3i_det_merge import m3i_pkg::*; #(
  parameter int W  = 32,
  parameter int NS = 39
) (
  input  logic                  clk,
  input  logic [NS-1:0]         en,
  input  logic signed [W-1:0]   a_in [3],
  input  logic signed [2*W:0]   cof [3],
  output logic [3*W-1:0]        dq [W],
  output det_flags_t            flags_end,
  output logic                  singular
);

  localparam int DW  = 3 * W + 2;  // signed determinant width
  localparam int DMW = 3 * W;      // determinant magnitude width

  logic signed [W-1:0]  a_s0 [3];
  logic signed [W-1:0]  a_s1 [3];
  logic signed [2*W:0]  plo [3];
  logic signed [2*W:0]  phi [3];
  logic signed [DW-1:0] term [3];
  logic signed [DW-1:0] det;
  logic signed [DW-1:0] det_abs;
  det_flags_t           fl [W+1];

  assign det_abs = det[DW-1] ? -det : det;

  always_ff @(posedge clk) begin
    // Column a travels beside the cofactor lanes.
    for (int i = 0; i < 3; i++) begin
      if (en[STG_PROD]) a_s0[i] <= a_in[i];
      if (en[STG_COF])  a_s1[i] <= a_s0[i];
    end
    // Each cofactor is split into a low unsigned half and a high signed half.
    if (en[STG_DPART]) begin
      for (int i = 0; i < 3; i++) begin
        plo[i] <= a_s1[i] * $signed({1'b0, cof[i][W-1:0]});
        phi[i] <= a_s1[i] * $signed(cof[i][2*W:W]);
      end
    end
    if (en[STG_DTERM]) begin
      for (int i = 0; i < 3; i++) begin
        term[i] <= (DW'(phi[i]) <<< W) + DW'(plo[i]);
      end
    end
    if (en[STG_DSUM]) det <= term[0] + term[1] + term[2];
    // Magnitude and flags, then a delay line matched to the divider stages.
    if (en[STG_DMAG]) begin
      dq[0] <= DMW'(det_abs);
      fl[0] <= '{neg: det[DW-1], zero: (det == '0)};
    end
    for (int k = 1; k < W; k++) begin
      if (en[STG_DMAG + k]) dq[k] <= dq[k-1];
    end
    for (int k = 1; k <= W; k++) begin
      if (en[STG_DMAG + k]) fl[k] <= fl[k-1];
    end
    if (en[NS-1]) singular <= fl[W].zero;
  end

  assign flags_end = fl[W];

endmodule

`default_nettype wire

### rtl/core/m3i_div_lane.sv
// One divider lane: (|cof| * 2^W) / |det|, one quotient bit per stage, then sign and saturation.
`default_nettype none

module m3i_div_lane import m3i_pkg::*; #(
  parameter int W  = 32,
  parameter int NS = 39
) (
  input  logic                clk,
  input  logic [NS-1:0]       en,
  input  logic signed [2*W:0] cof,
  input  logic [3*W-1:0]      dq [W],
  input  det_flags_t          flags_end,
  output logic signed [W-1:0] res
);

  localparam int DMW = 3 * W;

  logic signed [2*W:0] cof_abs;
  logic [2*W-1:0]      cmag [4];
  logic                cneg [4];
  logic [DMW-1:0]      r0;
  logic [DMW-1:0]      rem [W];
  logic [W-2:0]        quo [W];
  logic                sat [W];
  logic                sn  [W];
  logic [DMW:0]        trial [W];
  logic [DMW:0]        diff [W];
  logic                ge [W];
  logic                neg;
  logic [W-1:0]        qext;

  assign cof_abs = cof[2*W] ? -cof : cof;
  // Numerator shifted so the first remainder is 2|cof|; low bits are all zero.
  assign r0 = {{(W-1){1'b0}}, cmag[3], 1'b0};

  // Restoring step for each quotient stage.
  always_comb begin
    trial[0] = '0;
    diff[0]  = '0;
    ge[0]    = 1'b0;
    for (int j = 1; j < W; j++) begin
      trial[j] = {rem[j-1], 1'b0};
      diff[j]  = trial[j] - {1'b0, dq[j]};
      ge[j]    = (trial[j] >= {1'b0, dq[j]});
    end
  end

  assign neg  = sn[W-1] ^ flags_end.neg;
  assign qext = {1'b0, quo[W-1]};

  always_ff @(posedge clk) begin
    // Sign and magnitude, delayed until the determinant is ready.
    if (en[STG_DPART]) begin
      cneg[0] <= cof[2*W];
      cmag[0] <= cof_abs[2*W-1:0];
    end
    for (int k = 1; k < 4; k++) begin
      if (en[STG_DPART + k]) begin
        cneg[k] <= cneg[k-1];
        cmag[k] <= cmag[k-1];
      end
    end
    // Range check: the quotient reaches 2^(W-1) exactly when 2|cof| >= |det|.
    if (en[STG_DIV0]) begin
      rem[0] <= r0;
      quo[0] <= '0;
      sat[0] <= (r0 >= dq[0]);
      sn[0]  <= cneg[3];
    end
    for (int j = 1; j < W; j++) begin
      if (en[STG_DIV0 + j]) begin
        rem[j] <= ge[j] ? diff[j][DMW-1:0] : trial[j][DMW-1:0];
        quo[j] <= {quo[j-1][W-3:0], ge[j]};
        sat[j] <= sat[j-1];
        sn[j]  <= sn[j-1];
      end
    end
    // Final word: zero when singular, else signed and clamped.
    if (en[NS-1]) begin
      priority if (flags_end.zero) begin
        res <= '0;
      end else if (sat[W-1]) begin
        res <= neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
        res <= neg ? -qext : qext;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/matrix3x3_inverse_unit.sv
// Top level of the 3x3 fixed-point matrix inverse: nine cofactor lanes, determinant merge, nine divider lanes.
//
//   channel | dir | word                              | handshake
//   mat     | in  | m00..m22, signed Q(W/2).(W/2)     | valid/ready
//   inv     | out | r00..r22 saturated, singular flag | valid/ready
//
// One matrix enters per cycle unless a stalled output word holds the full pipeline.
// The divider lanes resolve one quotient bit per stage.
// Reset (rst, synchronous) empties the pipeline; data registers are not cleared.
// A stalled output word holds only the full stages directly behind it; empty
// stages keep filling, so input is taken until the whole pipeline is full.
`default_nettype none

module matrix3x3_inverse_unit import m3i_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  m3i_in_if.sink     mat,
  m3i_out_if.source  inv
);

  localparam int W  = WORD_BITS;
  localparam int NS = STG_DIV0 + W + 1;

  logic [NS-1:0]         valid;
  logic [NS-1:0]         valid_shift;
  logic [NS-1:0]         en;
  logic                  out_stall;
  logic signed [W-1:0]   op_p [9];
  logic signed [W-1:0]   op_q [9];
  logic signed [W-1:0]   op_r [9];
  logic signed [W-1:0]   op_s [9];
  logic signed [2*W:0]   cof [9];
  logic signed [2*W:0]   cof_row0 [3];
  logic signed [W-1:0]   col_a [3];
  logic [3*W-1:0]        dq [W];
  det_flags_t            flags_end;
  logic                  singular;
  logic signed [W-1:0]   res [9];

  // A stage holds only when it and every stage after it are full and the output is stalled.
  assign out_stall = valid[NS-1] & ~inv.ready;
  always_comb begin
    for (int s = 0; s < NS; s++) begin
      en[s] = ~(out_stall & (&(valid | ~({NS{1'b1}} << s))));
    end
  end

  assign valid_shift = {valid[NS-2:0], mat.valid};
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (en[s]) valid[s] <= valid_shift[s];
      end
    end
  end

  assign mat.ready = en[0];

  // Operand routing: rows of the inverse are b x c, c x a and a x b.
  always_comb begin
    op_p[0] = mat.m11; op_q[0] = mat.m22; op_r[0] = mat.m21; op_s[0] = mat.m12;
    op_p[1] = mat.m21; op_q[1] = mat.m02; op_r[1] = mat.m01; op_s[1] = mat.m22;
    op_p[2] = mat.m01; op_q[2] = mat.m12; op_r[2] = mat.m11; op_s[2] = mat.m02;
    op_p[3] = mat.m12; op_q[3] = mat.m20; op_r[3] = mat.m22; op_s[3] = mat.m10;
    op_p[4] = mat.m22; op_q[4] = mat.m00; op_r[4] = mat.m02; op_s[4] = mat.m20;
    op_p[5] = mat.m02; op_q[5] = mat.m10; op_r[5] = mat.m12; op_s[5] = mat.m00;
    op_p[6] = mat.m10; op_q[6] = mat.m21; op_r[6] = mat.m20; op_s[6] = mat.m11;
    op_p[7] = mat.m20; op_q[7] = mat.m01; op_r[7] = mat.m00; op_s[7] = mat.m21;
    op_p[8] = mat.m00; op_q[8] = mat.m11; op_r[8] = mat.m10; op_s[8] = mat.m01;
    col_a[0] = mat.m00;
    col_a[1] = mat.m10;
    col_a[2] = mat.m20;
    for (int i = 0; i < 3; i++) cof_row0[i] = cof[i];
  end

  // Cofactor lanes.
  for (genvar k = 0; k < 9; k++) begin : g_cof
    m3i_cof_lane #(.W(W), .NS(NS)) u_cof (
      .clk (clk),
      .en  (en),
      .p   (op_p[k]),
      .q   (op_q[k]),
      .r   (op_r[k]),
      .s   (op_s[k]),
      .cof (cof[k])
    );
  end

  // Determinant merge and its delay line for the dividers.
  m3i_det_merge #(.W(W), .NS(NS)) u_det (
    .clk       (clk),
    .en        (en),
    .a_in      (col_a),
    .cof       (cof_row0),
    .dq        (dq),
    .flags_end (flags_end),
    .singular  (singular)
  );

  // Divider lanes.
  for (genvar k = 0; k < 9; k++) begin : g_div
    m3i_div_lane #(.W(W), .NS(NS)) u_div (
      .clk       (clk),
      .en        (en),
      .cof       (cof[k]),
      .dq        (dq),
      .flags_end (flags_end),
      .res       (res[k])
    );
  end

  assign inv.valid    = valid[NS-1];
  assign inv.r00      = res[0];
  assign inv.r01      = res[1];
  assign inv.r02      = res[2];
  assign inv.r10      = res[3];
  assign inv.r11      = res[4];
  assign inv.r12      = res[5];
  assign inv.r20      = res[6];
  assign inv.r21      = res[7];
  assign inv.r22      = res[8];
  assign inv.singular = singular;

endmodule

`default_nettype wire

### rtl/core/m3i_checker.sv
// Port-level checks for the matrix inverse unit, attached by bind.
`default_nettype none

module m3i_checker #(
  parameter int W = 32
) (
  input logic           clk,
  input logic           rst,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input logic           singular,
  input logic [9*W-1:0] r_all
);

  // A singular word carries an all-zero inverse.
  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && singular |-> r_all == '0)
    else $error("singular word with nonzero entries");

  // With no word waiting at the output, the pipeline cannot be full.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked while output is empty");

  // A stalled word stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(r_all) && $stable(singular))
    else $error("stalled output word changed");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind matrix3x3_inverse_unit m3i_checker #(.W(WORD_BITS)) u_m3i_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (mat.ready),
  .out_valid (inv.valid),
  .out_ready (inv.ready),
  .singular  (inv.singular),
  .r_all     ({inv.r00, inv.r01, inv.r02, inv.r10, inv.r11, inv.r12,
               inv.r20, inv.r21, inv.r22})
);

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the 3x3 fixed-point matrix inverse unit.
`timescale 1ns / 1ps

module testbench;
  import m3i_pkg::*;

  localparam int W         = 32;
  localparam int LATENCY   = W + 7;
  localparam int MAX_CYCLES = 400000;

  typedef logic signed [W-1:0]   entry_t;
  typedef logic signed [191:0]   wide_t;
  typedef struct {
    entry_t m [9];
  } matrix_t;
  typedef struct {
    entry_t r [9];
    logic   singular;
  } inverse_t;

  localparam entry_t EMAX = {1'b0, {(W-1){1'b1}}};
  localparam entry_t EMIN = {1'b1, {(W-1){1'b0}}};
  localparam entry_t ONE  = entry_t'(1) <<< (W/2);

  logic clk;
  logic rst;
  logic steady;            // when set, neither side idles
  int   errors;
  int   cycles;
  int   sent;
  int   checked;
  int   singular_seen;
  int   saturated_seen;
  inverse_t expected_inverses [$];

  m3i_in_if  #(.WORD_BITS(W)) mat ();
  m3i_out_if #(.WORD_BITS(W)) inv ();

  matrix3x3_inverse_unit #(.WORD_BITS(W)) dut (
    .clk (clk),
    .rst (rst),
    .mat (mat),
    .inv (inv)
  );

  // Clock and cycle counter.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("Timeout at %0t after %0d cycles", $time, cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // Adjugate inverse with exact intermediates, truncating division and saturation.
  function automatic inverse_t invert_matrix(matrix_t x);
    wide_t    a [3];
    wide_t    b [3];
    wide_t    c [3];
    wide_t    cof [9];
    wide_t    det;
    wide_t    q;
    inverse_t res;
    for (int i = 0; i < 3; i++) begin
      a[i] = wide_t'(x.m[i*3]);
      b[i] = wide_t'(x.m[i*3+1]);
      c[i] = wide_t'(x.m[i*3+2]);
    end
    cof[0] = b[1]*c[2] - b[2]*c[1];
    cof[1] = b[2]*c[0] - b[0]*c[2];
    cof[2] = b[0]*c[1] - b[1]*c[0];
    cof[3] = c[1]*a[2] - c[2]*a[1];
    cof[4] = c[2]*a[0] - c[0]*a[2];
    cof[5] = c[0]*a[1] - c[1]*a[0];
    cof[6] = a[1]*b[2] - a[2]*b[1];
    cof[7] = a[2]*b[0] - a[0]*b[2];
    cof[8] = a[0]*b[1] - a[1]*b[0];
    det = a[0]*cof[0] + a[1]*cof[1] + a[2]*cof[2];
    res.singular = (det == 0);
    for (int i = 0; i < 9; i++) begin
      if (det == 0) begin
        res.r[i] = '0;
      end else begin
        q = (cof[i] <<< W) / det;
        if (q > wide_t'(EMAX)) q = wide_t'(EMAX);
        if (q < wide_t'(EMIN)) q = wide_t'(EMIN);
        res.r[i] = entry_t'(q);
      end
    end
    return res;
  endfunction

  // Sends one word; called and returning at a falling edge.
  task automatic send_matrix(matrix_t x);
    while (!steady && $urandom_range(99) < 33) begin
      mat.valid <= 1'b0;
      @(negedge clk);
    end
    mat.valid <= 1'b1;
    mat.m00 <= x.m[0]; mat.m01 <= x.m[1]; mat.m02 <= x.m[2];
    mat.m10 <= x.m[3]; mat.m11 <= x.m[4]; mat.m12 <= x.m[5];
    mat.m20 <= x.m[6]; mat.m21 <= x.m[7]; mat.m22 <= x.m[8];
    do @(posedge clk); while (!mat.ready);
    expected_inverses.push_back(invert_matrix(x));
    sent++;
    @(negedge clk);
  endtask

  // Output stalls.
  always @(negedge clk) begin
    if (rst) inv.ready <= 1'b0;
    else     inv.ready <= steady || ($urandom_range(99) >= 33);
  end

  // Result checker.
  always @(posedge clk) begin
    inverse_t want;
    entry_t   got [9];
    if (!rst && inv.valid && inv.ready) begin
      got = '{inv.r00, inv.r01, inv.r02, inv.r10, inv.r11, inv.r12,
              inv.r20, inv.r21, inv.r22};
      if (expected_inverses.size() == 0) begin
        $display("%0t: unexpected word, r00=%0d singular=%0b", $time, inv.r00, inv.singular);
        errors++;
      end else begin
        want = expected_inverses.pop_front();
        checked++;
        if (want.singular) singular_seen++;
        for (int i = 0; i < 9; i++) begin
          if (want.r[i] == EMAX || want.r[i] == EMIN) saturated_seen++;
          if (got[i] !== want.r[i]) begin
            $display("%0t: r%0d%0d expected %0d actual %0d", $time, i / 3, i % 3,
                     want.r[i], got[i]);
            errors++;
          end
        end
        if (inv.singular !== want.singular) begin
          $display("%0t: singular expected %0b actual %0b", $time, want.singular,
                   inv.singular);
          errors++;
        end
      end
    end
  end

  function automatic matrix_t make_matrix(entry_t e0, entry_t e1, entry_t e2,
                                          entry_t e3, entry_t e4, entry_t e5,
                                          entry_t e6, entry_t e7, entry_t e8);
    matrix_t x;
    x.m = '{e0, e1, e2, e3, e4, e5, e6, e7, e8};
    return x;
  endfunction

  // Entry of modest size: a few units with a random fraction.
  function automatic entry_t modest_entry();
    return entry_t'($signed($urandom_range(16 * (1 << 16))) - 8 * (1 << 16));
  endfunction

  // Corner matrices: identity, zero, extremes, tiny and negative determinants.
  task automatic test_directed();
    entry_t h;
    h = ONE >>> 1;
    send_matrix(make_matrix(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
    send_matrix(make_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_matrix(make_matrix(h, 0, 0, 0, h, 0, 0, 0, h));
    send_matrix(make_matrix(-ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
    send_matrix(make_matrix(0, ONE, 0, ONE, 0, 0, 0, 0, ONE));
    send_matrix(make_matrix(1, 0, 0, 0, 1, 0, 0, 0, 1));
    send_matrix(make_matrix(-1, 0, 0, 0, 1, 0, 0, 0, 1));
    send_matrix(make_matrix(EMAX, 0, 0, 0, EMAX, 0, 0, 0, EMAX));
    send_matrix(make_matrix(EMIN, 0, 0, 0, EMIN, 0, 0, 0, EMIN));
    send_matrix(make_matrix(EMIN, EMAX, EMIN, EMAX, EMIN, EMAX, EMIN, EMAX, EMAX));
    send_matrix(make_matrix(EMIN, EMIN, EMIN, EMIN, EMIN, EMIN, EMIN, EMIN, EMIN));
    send_matrix(make_matrix(-1, -1, -1, -1, -1, -1, -1, -1, -1));
    send_matrix(make_matrix(ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE,
                            7 * ONE, 8 * ONE, 9 * ONE));
    send_matrix(make_matrix(ONE, 2 * ONE, 3 * ONE, 0, ONE, 4 * ONE,
                            5 * ONE, 6 * ONE, 0));
    send_matrix(make_matrix(2 * ONE, 0, 0, 0, 4 * ONE, 0, 0, 0, -8 * ONE));
    send_matrix(make_matrix(ONE, ONE, 0, 0, ONE, ONE, ONE, 0, ONE + 1));
    send_matrix(make_matrix(EMAX, EMAX, 0, EMAX, EMIN, 0, 0, 0, 1));
  endtask

  // Random matrices: mostly well-conditioned, some singular, some full range.
  task automatic test_random(int count);
    matrix_t x;
    int      kind;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(9);
      for (int i = 0; i < 9; i++) begin
        if (kind < 3) x.m[i] = entry_t'($urandom);
        else          x.m[i] = modest_entry();
      end
      if (kind == 3) for (int i = 0; i < 3; i++) x.m[6+i] = x.m[i];
      if (kind == 4) for (int i = 0; i < 3; i++) x.m[i*3+2] = -x.m[i*3];
      if (kind == 5) for (int i = 0; i < 9; i++) x.m[i] = x.m[i] >>> 12;
      if (kind == 6) x.m[$urandom_range(8)] = ($urandom_range(1)) ? EMAX : EMIN;
      send_matrix(x);
    end
  endtask

  initial begin
    errors = 0; cycles = 0; sent = 0; checked = 0;
    singular_seen = 0; saturated_seen = 0;
    steady = 1'b0;
    rst = 1'b1;
    mat.valid = 1'b0;
    mat.m00 = '0; mat.m01 = '0; mat.m02 = '0;
    mat.m10 = '0; mat.m11 = '0; mat.m12 = '0;
    mat.m20 = '0; mat.m21 = '0; mat.m22 = '0;
    inv.ready = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_random(200);
    // Back-to-back words with no stalls on either side.
    steady = 1'b1;
    test_random(100);
    steady = 1'b0;
    test_random(200);
    mat.valid <= 1'b0;

    while (expected_inverses.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    $display("Sent %0d matrices, checked %0d inverses: %0d singular, %0d saturated entries",
             sent, checked, singular_seen, saturated_seen);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
